>>> design/stb_pkg.sv
// ----------------------------------------------------------------------------
// Seconds timer bank package
// Field widths, timer marks, command codes and controller states that the
// timer bank modules share.
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

	// Timer value width and the two special timer values
	localparam int unsigned TIMER_W = 16;
	localparam logic [TIMER_W-1:0] HALT_MARK = 16'hFFFF;
	localparam logic [TIMER_W-1:0] WRAP_MARK = 16'hFFFE;

	// Input field widths
	localparam int unsigned CMD_W = 3;
	localparam int unsigned IDX_W = 3;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned S_TDATA_W = 24;
	localparam int unsigned M_TDATA_W = 24;

	// Command codes carried in the input tuser field
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 3'd0,
		CMD_SET      = 3'd1,
		CMD_HALT     = 3'd2,
		CMD_CLEAR    = 3'd3,
		CMD_READ     = 3'd4,
		CMD_REMAIN   = 3'd5,
		CMD_COUNT_TO = 3'd6
	} cmd_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_TICK,
		ST_DONE
	} state_t;

endpackage : stb_pkg

`default_nettype wire

>>> design/stb_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered so that
// it appears in the cycle after the read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module stb_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : stb_ram

`default_nettype wire

>>> design/seconds_timer_bank.sv
// ----------------------------------------------------------------------------
// Seconds timer bank
// A bank of 16-bit up-counting second timers held in one RAM, with commands to
// tick, set, halt, clear, read, report remaining time and test against a target.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis stream, one per transfer; the command code
//   travels in s_axis_tuser. Every command produces exactly one result
//   transfer on the m_axis stream, in order.
//   The timer values live in a RAM with a registered read. A single-timer
//   command passes through the read, execute and done states: it reads its
//   entry, modifies it and writes it back, and its result is loaded into the
//   output register in the done state; the next command is taken once the
//   controller is back in idle. A tick walks the RAM with one read and one
//   write-back in flight each cycle; the walk length sets the tick rate.
//   Unused codes and out-of-range indices skip to done and return zero.
//   Reset clears a valid bit for every entry; an entry that has never been
//   written reads as zero, so no clearing pass is needed.
//   A finished result waits in the output register while the next command
//   is accepted and worked on. If the receiver keeps m_axis_tready low, the
//   following command holds in its final state until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_timer_bank
	import stb_pkg::*;
#(
	parameter int unsigned NUM_TIMERS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Command stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// tdata: timer_index [2:0], value [18:3], restart [19], zero [23:20]
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// tuser: cmd [2:0]
	input  wire logic [CMD_W-1:0]     s_axis_tuser,
	// Result stream
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// tdata: timer_value [15:0], fired [16], zero [23:17]
	output logic      [M_TDATA_W-1:0] m_axis_tdata
);

	localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

	// Input field views
	logic                 s_xfer;
	cmd_t                 cmd_in;
	logic [IDX_W-1:0]     idx_in;
	logic                 idx_ok;

	// Latched command
	cmd_t                 cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TIMER_W-1:0]   value_q;
	logic                 restart_q;
	logic [7:0]           idx_wide;
	logic [AW-1:0]        idx_addr;

	// Controller
	state_t               state_q;
	state_t               state_d;
	logic [CW-1:0]        tick_cnt_q;
	logic                 tick_rd_last;

	// RAM ports
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [TIMER_W-1:0]   rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [TIMER_W-1:0]   wr_data;

	// Entry valid bits and read pipeline
	logic [NUM_TIMERS-1:0] valid_q;
	logic                 rd_vld_s1;
	logic                 tick_wr_s1;
	logic [AW-1:0]        tick_addr_s1;

	// Datapath
	logic [TIMER_W-1:0]   cur;
	logic [TIMER_W-1:0]   target;
	logic [TIMER_W-1:0]   tick_val;
	logic                 ex_wr;
	logic [TIMER_W-1:0]   ex_data;
	logic [TIMER_W-1:0]   ex_res;
	logic                 ex_fired;

	// Result and output registers
	logic [TIMER_W-1:0]   res_q;
	logic                 fired_q;
	logic                 out_vld_q;
	logic [TIMER_W-1:0]   out_val_q;
	logic                 out_fired_q;
	logic                 out_free;

	// Field extraction
	assign s_xfer   = s_axis_tvalid & s_axis_tready;
	assign cmd_in   = cmd_t'(s_axis_tuser);
	assign idx_in   = s_axis_tdata[IDX_W-1:0];
	assign idx_ok   = 9'(idx_in) < 9'(NUM_TIMERS);
	assign idx_wide = 8'(idx_q);
	assign idx_addr = idx_wide[AW-1:0];
	assign out_free = ~out_vld_q | m_axis_tready;
	assign tick_rd_last = tick_cnt_q == CW'(NUM_TIMERS);

	// Command latch
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cmd_q     <= cmd_in;
			idx_q     <= idx_in;
			value_q   <= s_axis_tdata[IDX_W +: TIMER_W];
			restart_q <= s_axis_tdata[IDX_W + TIMER_W];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_xfer) begin
					if (cmd_in == CMD_TICK) begin
						state_d = ST_TICK;
					end else if (idx_ok && (cmd_in inside {[CMD_SET:CMD_COUNT_TO]})) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: state_d = ST_DONE;
			ST_TICK: begin
				if (tick_rd_last && tick_wr_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = idx_addr;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_READ: rd_en = 1'b1;
			ST_TICK: begin
				rd_en   = ~tick_rd_last;
				rd_addr = tick_cnt_q[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Tick walk counter and write-back stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= '0;
			tick_wr_s1 <= 1'b0;
		end else begin
			if (s_xfer) begin
				tick_cnt_q <= '0;
			end else if (state_q == ST_TICK && rd_en) begin
				tick_cnt_q <= tick_cnt_q + CW'(1);
			end
			tick_wr_s1 <= (state_q == ST_TICK) && rd_en;
		end
	end

	// Address and valid bit travel alongside the RAM read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			tick_addr_s1 <= rd_addr;
			rd_vld_s1    <= valid_q[rd_addr];
		end
	end

	// Entry valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Timer arithmetic on the value read back
	always_comb begin
		cur      = rd_vld_s1 ? rd_data : '0;
		target   = (value_q > WRAP_MARK) ? WRAP_MARK : value_q;
		tick_val = cur;
		if (cur < WRAP_MARK) begin
			tick_val = cur + TIMER_W'(1);
		end else if (cur == WRAP_MARK) begin
			tick_val = '0;
		end
		ex_wr    = 1'b0;
		ex_data  = cur;
		ex_res   = '0;
		ex_fired = 1'b0;
		case (cmd_q)
			CMD_SET: begin
				ex_wr   = 1'b1;
				ex_data = value_q;
				ex_res  = value_q;
			end
			CMD_HALT: begin
				ex_wr   = 1'b1;
				ex_data = HALT_MARK;
				ex_res  = HALT_MARK;
			end
			CMD_CLEAR: begin
				ex_wr   = 1'b1;
				ex_data = '0;
			end
			CMD_READ: ex_res = cur;
			CMD_REMAIN: begin
				ex_res = (value_q > cur) ? value_q - cur : '0;
			end
			CMD_COUNT_TO: begin
				ex_res = cur;
				if (cur >= target) begin
					if (restart_q) begin
						ex_wr    = 1'b1;
						ex_data  = '0;
						ex_res   = '0;
						ex_fired = 1'b1;
					end else if (cur != HALT_MARK) begin
						ex_wr    = 1'b1;
						ex_data  = HALT_MARK;
						ex_res   = HALT_MARK;
						ex_fired = 1'b1;
					end
				end
			end
			default: begin
				ex_wr = 1'b0;
			end
		endcase
	end

	// Write port selection
	always_comb begin
		if (state_q == ST_TICK) begin
			wr_en   = tick_wr_s1;
			wr_addr = tick_addr_s1;
			wr_data = tick_val;
		end else begin
			wr_en   = (state_q == ST_EXEC) && ex_wr;
			wr_addr = idx_addr;
			wr_data = ex_data;
		end
	end

	stb_ram #(
		.WIDTH (TIMER_W),
		.DEPTH (NUM_TIMERS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result register: zero unless a single-timer command fills it
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			res_q   <= '0;
			fired_q <= 1'b0;
		end else if (state_q == ST_EXEC) begin
			res_q   <= ex_res;
			fired_q <= ex_fired;
		end
	end

	// Output register, loaded when the previous result has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_val_q   <= res_q;
			out_fired_q <= fired_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(M_TDATA_W - TIMER_W - 1)'(0), out_fired_q, out_val_q};

	// Checks on the controller and the RAM pipeline
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_TICK || state_q == ST_EXEC))
		else $error("timer RAM written outside a tick walk or command update");

	a_tick_wb: assert property (@(posedge clk) disable iff (!arst_n)
		tick_wr_s1 |-> $past(rd_en))
		else $error("tick write-back without a preceding read");

	a_tick_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK && state_d == ST_DONE) |-> tick_rd_last)
		else $error("tick walk ended before every timer was read");

	a_tick_all: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && $past(state_q) == ST_TICK) |-> (&valid_q))
		else $error("tick walk left a timer entry unwritten");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> !s_axis_tready)
		else $error("second command accepted before the first finished");

endmodule : seconds_timer_bank

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Seconds timer bank testbench
// Drives timer commands into the command stream and checks every result
// transfer against a cycle-free prediction of the timer bank. A directed set
// of commands covers the field extremes and the corner cases of each command.
// Three phases of weighted random traffic follow, each with its own pattern
// of idle cycles on the command and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
	import stb_pkg::*;
();

	localparam int unsigned NUM_TIMERS = 8;
	// Command code that the block does not define
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	// Cycles of a tick walk plus margin, used for the final settle
	localparam int unsigned SETTLE_CYCLES = 2 * (NUM_TIMERS + 3);
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [TIMER_W-1:0] timer_value;
		logic               fired;
	} timer_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [CMD_W-1:0]     s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	// Expected timer state and the replies still to come
	logic [TIMER_W-1:0] shadow_timers [NUM_TIMERS];
	timer_reply_t       replies_due [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatches = 0;
	int unsigned replies_checked = 0;
	int unsigned cmds_sent [8];
	int unsigned fires_seen = 0;

	seconds_timer_bank #(
		.NUM_TIMERS(NUM_TIMERS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the reply to one command and updates the expected timers.
	function automatic timer_reply_t apply_timer_command(logic [CMD_W-1:0] cmd,
			logic [IDX_W-1:0] idx, logic [TIMER_W-1:0] value, logic restart);
		timer_reply_t       reply;
		logic [TIMER_W-1:0] target;
		logic [TIMER_W-1:0] now;
		reply = '0;
		if (cmd == CMD_TICK) begin
			for (int k = 0; k < NUM_TIMERS; k++) begin
				if (shadow_timers[k] < WRAP_MARK)
					shadow_timers[k] = shadow_timers[k] + 1'b1;
				else if (shadow_timers[k] == WRAP_MARK)
					shadow_timers[k] = '0;
			end
			return reply;
		end
		if (int'(idx) >= NUM_TIMERS)
			return reply;
		now = shadow_timers[idx];
		case (cmd)
			CMD_SET: begin
				shadow_timers[idx] = value;
				reply.timer_value = value;
			end
			CMD_HALT: begin
				shadow_timers[idx] = HALT_MARK;
				reply.timer_value = HALT_MARK;
			end
			CMD_CLEAR: begin
				shadow_timers[idx] = '0;
			end
			CMD_READ: begin
				reply.timer_value = now;
			end
			CMD_REMAIN: begin
				reply.timer_value = (value > now) ? value - now : '0;
			end
			CMD_COUNT_TO: begin
				// Targets beyond the wrap point are pulled back to it
				target = (value > WRAP_MARK) ? WRAP_MARK : value;
				if (now >= target) begin
					if (restart) begin
						shadow_timers[idx] = '0;
						reply.fired = 1'b1;
					end else if (now != HALT_MARK) begin
						shadow_timers[idx] = HALT_MARK;
						reply.fired = 1'b1;
					end
				end
				reply.timer_value = shadow_timers[idx];
			end
			default: begin
			end
		endcase
		return reply;
	endfunction

	task automatic report_mismatch(string what, timer_reply_t want, timer_reply_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] %s: expected value %0d fired %0d, got value %0d fired %0d",
				$time, what, want.timer_value, want.fired, got.timer_value, got.fired);
	endtask

	// Checks the result transfer of this edge first, then records the
	// expectation for any command transfer of the same edge.
	always @(posedge clk) begin : check_and_predict
		timer_reply_t got;
		timer_reply_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.timer_value = m_axis_tdata[TIMER_W-1:0];
				got.fired = m_axis_tdata[TIMER_W];
				replies_checked++;
				if (got.fired)
					fires_seen++;
				if (replies_due.size() == 0) begin
					report_mismatch("result with nothing awaited", '0, got);
				end else begin
					want = replies_due.pop_front();
					if (got.timer_value != want.timer_value || got.fired != want.fired)
						report_mismatch("result mismatch", want, got);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cmds_sent[s_axis_tuser]++;
				replies_due.push_back(apply_timer_command(s_axis_tuser,
					s_axis_tdata[IDX_W-1:0], s_axis_tdata[IDX_W +: TIMER_W],
					s_axis_tdata[IDX_W + TIMER_W]));
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Presents one command and holds it until the transfer takes place.
	task automatic send_timer_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [TIMER_W-1:0] value, input logic restart);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0000, restart, value, idx};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Stops sending and waits until every awaited result has come back.
	task automatic drain_replies();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_set_halt_clear_read();
		send_timer_cmd(CMD_SET, 3'd0, 16'h0000, 1'b0);
		send_timer_cmd(CMD_SET, 3'd5, 16'hAAAA, 1'b1);
		send_timer_cmd(CMD_SET, 3'd6, 16'h5555, 1'b0);
		send_timer_cmd(CMD_READ, 3'd5, 16'h0000, 1'b0);
		send_timer_cmd(CMD_HALT, 3'd2, 16'hFFFF, 1'b1);
		send_timer_cmd(CMD_READ, 3'd2, 16'h0000, 1'b0);
		send_timer_cmd(CMD_CLEAR, 3'd5, 16'hFFFF, 1'b0);
		drain_replies();
	endtask

	// A timer at the wrap point goes to zero; a halted one stays put.
	task automatic test_tick_wrap();
		send_timer_cmd(CMD_SET, 3'd1, WRAP_MARK, 1'b0);
		send_timer_cmd(CMD_SET, 3'd7, HALT_MARK, 1'b0);
		send_timer_cmd(CMD_TICK, 3'd7, 16'hFFFF, 1'b1);
		send_timer_cmd(CMD_READ, 3'd1, 16'h0000, 1'b0);
		send_timer_cmd(CMD_READ, 3'd7, 16'h0000, 1'b0);
		drain_replies();
	endtask

	// Remaining time saturates at zero, including on a halted timer.
	task automatic test_remaining();
		send_timer_cmd(CMD_SET, 3'd3, 16'd100, 1'b0);
		send_timer_cmd(CMD_REMAIN, 3'd3, 16'd150, 1'b0);
		send_timer_cmd(CMD_REMAIN, 3'd3, 16'd100, 1'b0);
		send_timer_cmd(CMD_REMAIN, 3'd3, 16'd0, 1'b0);
		send_timer_cmd(CMD_REMAIN, 3'd2, HALT_MARK, 1'b0);
		drain_replies();
	endtask

	// Clamped target, one-shot firing, restart of a halted timer.
	task automatic test_count_to();
		send_timer_cmd(CMD_COUNT_TO, 3'd3, HALT_MARK, 1'b0);
		send_timer_cmd(CMD_COUNT_TO, 3'd3, 16'd100, 1'b0);
		send_timer_cmd(CMD_COUNT_TO, 3'd3, 16'd100, 1'b0);
		send_timer_cmd(CMD_COUNT_TO, 3'd3, HALT_MARK, 1'b1);
		send_timer_cmd(CMD_SET, 3'd4, WRAP_MARK, 1'b0);
		send_timer_cmd(CMD_COUNT_TO, 3'd4, HALT_MARK, 1'b0);
		send_timer_cmd(CMD_COUNT_TO, 3'd6, 16'd0, 1'b1);
		drain_replies();
	endtask

	// The spare command code must leave every timer alone.
	task automatic test_unused_code();
		send_timer_cmd(CMD_UNUSED, 3'd7, 16'hFFFF, 1'b1);
		send_timer_cmd(CMD_READ, 3'd6, 16'h0000, 1'b0);
		drain_replies();
	endtask

	// Value biased towards zero, the wrap point and the timer's own count,
	// so that targets are often just met or just missed.
	function automatic logic [TIMER_W-1:0] pick_timer_value(logic [IDX_W-1:0] idx);
		case ($urandom_range(3))
			0: return TIMER_W'($urandom);
			1: return TIMER_W'($urandom_range(20));
			2: return TIMER_W'(65535 - $urandom_range(15));
			default: return shadow_timers[idx] + TIMER_W'($urandom_range(6)) - TIMER_W'(3);
		endcase
	endfunction

	task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
			int unsigned count);
		int unsigned      roll;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 20)
				cmd = CMD_TICK;
			else if (roll < 32)
				cmd = CMD_SET;
			else if (roll < 38)
				cmd = CMD_HALT;
			else if (roll < 44)
				cmd = CMD_CLEAR;
			else if (roll < 58)
				cmd = CMD_READ;
			else if (roll < 74)
				cmd = CMD_REMAIN;
			else if (roll < 96)
				cmd = CMD_COUNT_TO;
			else
				cmd = CMD_UNUSED;
			idx = IDX_W'($urandom_range(NUM_TIMERS - 1));
			send_timer_cmd(cmd, idx, pick_timer_value(idx), 1'($urandom_range(1)));
		end
		drain_replies();
	endtask

	initial begin
		for (int k = 0; k < NUM_TIMERS; k++)
			shadow_timers[k] = '0;
		send_idle_pct = 14;
		recv_idle_pct = 61;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_set_halt_clear_read();
		test_tick_wrap();
		test_remaining();
		test_count_to();
		test_unused_code();
		test_random_traffic(14, 61, 260);
		test_random_traffic(61, 14, 260);
		test_random_traffic(0, 0, 260);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (replies_due.size() != 0)
			report_mismatch("result never arrived", replies_due[0], '0);

		$display("Covered %0d results, %0d of them fired; ticks %0d, count_to %0d.",
			replies_checked, fires_seen, cmds_sent[CMD_TICK], cmds_sent[CMD_COUNT_TO]);
		$display("Also set %0d, halt %0d, clear %0d, read %0d, remaining %0d, spare code %0d.",
			cmds_sent[CMD_SET], cmds_sent[CMD_HALT], cmds_sent[CMD_CLEAR],
			cmds_sent[CMD_READ], cmds_sent[CMD_REMAIN], cmds_sent[CMD_UNUSED]);
		if (mismatches == 0) begin
			$display("seconds_timer_bank verification clean");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("seconds_timer_bank verification failed");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2000000;
		$display("Timed out with %0d results still awaited.", replies_due.size());
		$display("seconds_timer_bank verification failed");
		$finish;
	end

endmodule : testbench

`default_nettype wire
